FILE: rtl/bsr_pkg.sv
package bsr_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int QueueDepth   = 4;

  localparam int KindW   = 3;
  localparam int CoordW  = 16;
  localparam int DataW   = 32;
  localparam int CfgIdxW = 2;
  localparam int SizeW   = 9;
  localparam int ThickW  = 8;
  localparam int RadW    = 4;
  localparam int PtW     = 18;
  localparam int RemW    = 19;

  localparam logic [KindW-1:0] KindStart = 3'd0;
  localparam logic [KindW-1:0] KindMove  = 3'd1;
  localparam logic [KindW-1:0] KindStop  = 3'd2;
  localparam logic [KindW-1:0] KindRead  = 3'd3;
  localparam logic [KindW-1:0] KindWrite = 3'd4;

  localparam logic [SizeW-1:0]  CanvasSizeReset = 9'd256;
  localparam logic [ThickW-1:0] ThickReset      = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_THICK,
    CFG_COLOR
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_STAMP,
    OP_LINE,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CoordW-1:0]        dw;
    logic [CoordW-1:0]        dh;
    logic                     rising;
    logic [DataW-1:0]         data;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LINE,
    S_LINE_NEXT,
    S_SETUP,
    S_STAMP,
    S_READ_WAIT,
    S_DONE
  } state_t;

  function automatic logic [RadW-1:0] brush_radius(input logic [ThickW-1:0] t);
    logic [RadW-1:0] cnt;
    cnt = '0;
    for (int k = 1; k < 16; k++) begin
      if (9'(k * k) < {1'b0, t}) begin
        cnt = cnt + 1'b1;
      end
    end
    return cnt;
  endfunction

endpackage

FILE: rtl/bsr_ifs.sv
interface bsr_item_if;
  logic                                     valid;
  logic                                     ready;
  logic [bsr_pkg::KindW-1:0]                kind;
  logic signed [bsr_pkg::CoordW-1:0]        pos_x;
  logic signed [bsr_pkg::CoordW-1:0]        pos_y;
  logic [bsr_pkg::DataW-1:0]                write_data;
  modport source(output valid, kind, pos_x, pos_y, write_data, input ready);
  modport sink(input valid, kind, pos_x, pos_y, write_data, output ready);
endinterface

interface bsr_result_if;
  logic                      valid;
  logic                      ready;
  logic [bsr_pkg::DataW-1:0] read_data;
  logic                      outside;
  modport source(output valid, read_data, outside, input ready);
  modport sink(input valid, read_data, outside, output ready);
endinterface

interface bsr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bsr_pkg::CfgIdxW-1:0] index;
  logic [bsr_pkg::DataW-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/bsr_queue.sv
module bsr_queue #(
  parameter int DEPTH = bsr_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  bsr_pkg::cmd_t push_cmd,
  input  logic          push_valid,
  output logic          push_ready,
  output bsr_pkg::cmd_t pop_cmd,
  output logic          pop_valid,
  input  logic          pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bsr_pkg::cmd_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/bsr_front.sv
module bsr_front (
  input  logic              clk,
  input  logic              rst,
  bsr_item_if.sink          items,
  input  logic              clearing,
  output bsr_pkg::cmd_t     cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);

  logic signed [bsr_pkg::CoordW-1:0] last_x;
  logic signed [bsr_pkg::CoordW-1:0] last_y;
  logic signed [bsr_pkg::CoordW-1:0] bx, ex, by, ey;
  logic [bsr_pkg::CoordW-1:0]        dw, dh;
  logic                              rising;
  logic                              accept;

  assign items.ready = cmd_ready && !clearing;
  assign cmd_valid   = items.valid && !clearing;
  assign accept      = items.valid && items.ready;

  always_comb begin
    bx = (items.pos_x < last_x) ? items.pos_x : last_x;
    ex = (items.pos_x > last_x) ? items.pos_x : last_x;
    by = (items.pos_y < last_y) ? items.pos_y : last_y;
    ey = (items.pos_y > last_y) ? items.pos_y : last_y;
    dw = $unsigned(ex) - $unsigned(bx);
    dh = $unsigned(ey) - $unsigned(by);
    rising = ((items.pos_y >= last_y) && (items.pos_x >= last_x)) ||
             ((items.pos_y <= last_y) && (items.pos_x <= last_x));
    cmd        = '0;
    cmd.op     = bsr_pkg::OP_NOP;
    cmd.x      = items.pos_x;
    cmd.y      = items.pos_y;
    cmd.data   = items.write_data;
    unique case (items.kind)
      bsr_pkg::KindStart: cmd.op = bsr_pkg::OP_STAMP;
      bsr_pkg::KindMove, bsr_pkg::KindStop: begin
        cmd.x      = bx;
        cmd.y      = by;
        cmd.dw     = dw;
        cmd.dh     = dh;
        cmd.rising = rising;
        cmd.op     = ((dw == '0) && (dh == '0)) ? bsr_pkg::OP_NOP : bsr_pkg::OP_LINE;
      end
      bsr_pkg::KindRead:  cmd.op = bsr_pkg::OP_READ;
      bsr_pkg::KindWrite: cmd.op = bsr_pkg::OP_WRITE;
      default:            cmd.op = bsr_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
    end else if (accept &&
                 ((items.kind == bsr_pkg::KindStart) || (items.kind == bsr_pkg::KindMove))) begin
      last_x <= items.pos_x;
      last_y <= items.pos_y;
    end
  end

endmodule

FILE: rtl/bsr_back.sv
module bsr_back #(
  parameter int MAX_WIDTH  = bsr_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bsr_pkg::MaxHeightDef
) (
  input  logic          clk,
  input  logic          rst,
  bsr_cfg_if.sink       cfg,
  bsr_result_if.source  results,
  input  bsr_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  output logic          clearing
);

  localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LimW   = $clog2(MaxDim + 1);
  localparam int SzW    = (LimW > bsr_pkg::SizeW) ? LimW : bsr_pkg::SizeW;
  localparam int PtW    = bsr_pkg::PtW;
  localparam int RemW   = bsr_pkg::RemW;
  localparam int CoordW = bsr_pkg::CoordW;
  localparam int DataW  = bsr_pkg::DataW;

  bsr_pkg::state_t state, state_next;

  logic [bsr_pkg::SizeW-1:0]  canvas_width;
  logic [bsr_pkg::SizeW-1:0]  canvas_height;
  logic [bsr_pkg::ThickW-1:0] thick;
  logic [DataW-1:0]           color;
  logic [bsr_pkg::RadW-1:0]   radius;

  logic [DataW-1:0] mem [Depth];
  logic             mem_we;
  logic             mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [DataW-1:0] mem_wdata;
  logic [DataW-1:0] rd_q;
  logic [AddrW-1:0] clr_addr;

  bsr_pkg::cmd_t     cur;
  logic [CoordW-1:0] idx, major, minor, q, minoff;
  logic signed [RemW-1:0] rem, rsum, rdif, ext_major, ext_minor;
  logic              xmaj, down, flip, in_line;

  logic signed [PtW-1:0] cx, cy;
  logic signed [PtW-1:0] xlo, xhi, ylo, yhi, x0c, x1c, y0c, y1c, wlast, hlast;
  logic [XW-1:0]         x0, x1, l;
  logic [YW-1:0]         y1, k;
  logic                  empty, hit, outside, cfg_we;
  logic signed [PtW-1:0] dxs, dys;
  logic signed [4:0]     dxn, dyn;
  logic [3:0]            ax, ay;
  logic [8:0]            dsq;
  logic [SzW-1:0]        cw_ext, ch_ext, eff_w, eff_h;

  logic             res_out, out_valid, out_outside;
  logic [DataW-1:0] res_data, out_data;
  bsr_pkg::state_t  ret_state;

  assign cfg.ready         = 1'b1;
  assign cfg_we            = cfg.valid && cfg.ready;
  assign results.valid     = out_valid;
  assign results.read_data = out_data;
  assign results.outside   = out_outside;
  assign clearing          = (state == bsr_pkg::S_CLEAR);
  assign cmd_ready         = (state == bsr_pkg::S_IDLE);

  always_comb begin
    cw_ext = SzW'(canvas_width);
    ch_ext = SzW'(canvas_height);
    if (canvas_width == '0) begin
      eff_w = SzW'(1);
    end else if (cw_ext > SzW'(MAX_WIDTH)) begin
      eff_w = SzW'(MAX_WIDTH);
    end else begin
      eff_w = cw_ext;
    end
    if (canvas_height == '0) begin
      eff_h = SzW'(1);
    end else if (ch_ext > SzW'(MAX_HEIGHT)) begin
      eff_h = SzW'(MAX_HEIGHT);
    end else begin
      eff_h = ch_ext;
    end
    wlast = $signed(PtW'(eff_w)) - PtW'(1);
    hlast = $signed(PtW'(eff_h)) - PtW'(1);
  end

  always_comb begin
    xlo   = cx - $signed(PtW'(radius));
    xhi   = cx + $signed(PtW'(radius));
    ylo   = cy - $signed(PtW'(radius));
    yhi   = cy + $signed(PtW'(radius));
    x0c   = (xlo < 0) ? '0 : xlo;
    x1c   = (xhi > wlast) ? wlast : xhi;
    y0c   = (ylo < 0) ? '0 : ylo;
    y1c   = (yhi > hlast) ? hlast : yhi;
    empty = (x0c > x1c) || (y0c > y1c);
    dxs   = cx - $signed(PtW'(l));
    dys   = cy - $signed(PtW'(k));
    dxn   = dxs[4:0];
    dyn   = dys[4:0];
    ax    = (dxn < 0) ? 4'(-dxn) : 4'(dxn);
    ay    = (dyn < 0) ? 4'(-dyn) : 4'(dyn);
    dsq   = 9'(ax) * 9'(ax) + 9'(ay) * 9'(ay);
    hit   = (dsq < {1'b0, thick});
    outside = (cur.x < 0) || (cur.y < 0) || (PtW'(cur.x) > wlast) || (PtW'(cur.y) > hlast);
    minoff  = flip ? (minor - q) : q;
    ext_major = $signed(RemW'(major));
    ext_minor = $signed(RemW'(minor));
    rsum      = rem + ext_minor;
    rdif      = rem - ext_minor;
    ret_state = in_line ? bsr_pkg::S_LINE_NEXT : bsr_pkg::S_DONE;
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = AddrW'(k) * AddrW'(MAX_WIDTH) + AddrW'(l);
    mem_wdata  = color;
    unique case (state)
      bsr_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AddrW'(Depth - 1)) begin
          state_next = bsr_pkg::S_IDLE;
        end
      end
      bsr_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_next = bsr_pkg::S_DECODE;
        end
      end
      bsr_pkg::S_DECODE: begin
        mem_addr  = AddrW'(cur.y[YW-1:0]) * AddrW'(MAX_WIDTH) + AddrW'(cur.x[XW-1:0]);
        mem_wdata = cur.data;
        unique case (cur.op)
          bsr_pkg::OP_STAMP: state_next = bsr_pkg::S_SETUP;
          bsr_pkg::OP_LINE:  state_next = bsr_pkg::S_LINE;
          bsr_pkg::OP_READ: begin
            mem_re     = !outside;
            state_next = outside ? bsr_pkg::S_DONE : bsr_pkg::S_READ_WAIT;
          end
          bsr_pkg::OP_WRITE: begin
            mem_we     = !outside;
            state_next = bsr_pkg::S_DONE;
          end
          default: state_next = bsr_pkg::S_DONE;
        endcase
      end
      bsr_pkg::S_LINE: state_next = bsr_pkg::S_SETUP;
      bsr_pkg::S_LINE_NEXT: begin
        state_next = (idx == major) ? bsr_pkg::S_DONE : bsr_pkg::S_LINE;
      end
      bsr_pkg::S_SETUP: begin
        state_next = ((thick == '0) || empty) ? ret_state : bsr_pkg::S_STAMP;
      end
      bsr_pkg::S_STAMP: begin
        mem_we = hit;
        if ((l == x1) && (k == y1)) begin
          state_next = ret_state;
        end
      end
      bsr_pkg::S_READ_WAIT: state_next = bsr_pkg::S_DONE;
      bsr_pkg::S_DONE: begin
        if (!out_valid || results.ready) begin
          state_next = bsr_pkg::S_IDLE;
        end
      end
      default: state_next = bsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bsr_pkg::S_CLEAR;
      clr_addr      <= '0;
      canvas_width  <= bsr_pkg::CanvasSizeReset;
      canvas_height <= bsr_pkg::CanvasSizeReset;
      thick         <= bsr_pkg::ThickReset;
      color         <= '0;
      radius        <= bsr_pkg::brush_radius(bsr_pkg::ThickReset);
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (bsr_pkg::cfg_idx_t'(cfg.index))
          bsr_pkg::CFG_WIDTH:  canvas_width  <= cfg.data[bsr_pkg::SizeW-1:0];
          bsr_pkg::CFG_HEIGHT: canvas_height <= cfg.data[bsr_pkg::SizeW-1:0];
          bsr_pkg::CFG_THICK: begin
            thick  <= cfg.data[bsr_pkg::ThickW-1:0];
            radius <= bsr_pkg::brush_radius(cfg.data[bsr_pkg::ThickW-1:0]);
          end
          bsr_pkg::CFG_COLOR:  color <= cfg.data;
          default: ;
        endcase
      end
      if (state == bsr_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if ((state == bsr_pkg::S_DONE) && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bsr_pkg::S_IDLE: begin
        cur      <= cmd;
        res_data <= '0;
        res_out  <= 1'b0;
      end
      bsr_pkg::S_DECODE: begin
        cx      <= PtW'(cur.x);
        cy      <= PtW'(cur.y);
        in_line <= 1'b0;
        xmaj    <= (cur.dw > cur.dh);
        major   <= (cur.dw > cur.dh) ? cur.dw : cur.dh;
        minor   <= (cur.dw > cur.dh) ? cur.dh : cur.dw;
        down    <= (cur.dw > cur.dh) && !cur.rising;
        flip    <= !(cur.dw > cur.dh) && !cur.rising;
        q       <= ((cur.dw > cur.dh) && !cur.rising) ? cur.dh : '0;
        rem     <= '0;
        idx     <= '0;
        if (((cur.op == bsr_pkg::OP_READ) || (cur.op == bsr_pkg::OP_WRITE)) && outside) begin
          res_out <= 1'b1;
        end
      end
      bsr_pkg::S_LINE: begin
        cx      <= PtW'(cur.x) + $signed(PtW'(xmaj ? idx : minoff));
        cy      <= PtW'(cur.y) + $signed(PtW'(xmaj ? minoff : idx));
        in_line <= 1'b1;
      end
      bsr_pkg::S_LINE_NEXT: begin
        idx <= idx + 1'b1;
        if (down) begin
          if (rdif < 0) begin
            rem <= rdif + ext_major;
            q   <= q - 1'b1;
          end else begin
            rem <= rdif;
          end
        end else begin
          if (rsum >= ext_major) begin
            rem <= rsum - ext_major;
            q   <= q + 1'b1;
          end else begin
            rem <= rsum;
          end
        end
      end
      bsr_pkg::S_SETUP: begin
        x0 <= x0c[XW-1:0];
        x1 <= x1c[XW-1:0];
        y1 <= y1c[YW-1:0];
        l  <= x0c[XW-1:0];
        k  <= y0c[YW-1:0];
      end
      bsr_pkg::S_STAMP: begin
        if (l == x1) begin
          l <= x0;
          k <= k + 1'b1;
        end else begin
          l <= l + 1'b1;
        end
      end
      bsr_pkg::S_READ_WAIT: res_data <= rd_q;
      bsr_pkg::S_DONE: begin
        if (!out_valid || results.ready) begin
          out_data    <= res_data;
          out_outside <= res_out;
        end
      end
      default: ;
    endcase
  end

  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == bsr_pkg::S_CLEAR) |-> !out_valid)
    else $error("result shown during clearing pass");

  a_scan_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == bsr_pkg::S_STAMP) |-> ((k <= y1) && (l <= x1) && (l >= x0)))
    else $error("stamp scan left its window");

  a_line_index: assert property (@(posedge clk) disable iff (rst)
    (state == bsr_pkg::S_LINE) |-> (idx <= major))
    else $error("line index past major extent");

  a_line_rem: assert property (@(posedge clk) disable iff (rst)
    (state == bsr_pkg::S_LINE) |-> ((rem >= 0) && (rem < ext_major)))
    else $error("line remainder out of range");

endmodule

FILE: rtl/brush_stroke_rasterizer_top.sv
// Round-brush stroke painter over a MAX_WIDTH x MAX_HEIGHT store of 32-bit pixels.
// After reset the store is swept to zero, one pixel a cycle; items are held
// off during that pass while configuration writes are taken. Items enter a
// QUEUE_DEPTH-entry queue (four by default) and are then executed one at a
// time by a single-port pixel memory doing one access per cycle. A start
// stamps the brush over its clipped square of at most (2r+1)^2 pixels, with r
// the largest value such that r^2 < brush_thickness; a move or stop stamps it
// at each of D+1 points along the line, where D is the larger of the two
// deltas, and stamps nothing when both deltas are zero.
module brush_stroke_rasterizer_top #(
  parameter int MAX_WIDTH   = bsr_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT  = bsr_pkg::MaxHeightDef,
  parameter int QUEUE_DEPTH = bsr_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst,
  bsr_item_if.sink     items,
  bsr_result_if.source results,
  bsr_cfg_if.sink      cfg
);

  bsr_pkg::cmd_t push_cmd;
  bsr_pkg::cmd_t pop_cmd;
  logic          push_valid, push_ready, pop_valid, pop_ready, clearing;

  bsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .clearing  (clearing),
    .cmd       (push_cmd),
    .cmd_valid (push_valid),
    .cmd_ready (push_ready)
  );

  bsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  bsr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .results   (results),
    .cmd       (pop_cmd),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .clearing  (clearing)
  );

endmodule

FILE: tb/brush_stroke_rasterizer_top_tb.sv
module brush_stroke_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CanvasMax = 256;
  localparam logic [bsr_pkg::KindW-1:0] KindSpare = 3'd5;

  typedef struct {
    logic [bsr_pkg::DataW-1:0] read_data;
    logic                      outside;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsr_item_if   items_if();
  bsr_result_if results_if();
  bsr_cfg_if    cfg_if();

  brush_stroke_rasterizer_top u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always #4 clk = ~clk;

  logic [bsr_pkg::DataW-1:0] canvas_px [CanvasMax*CanvasMax];
  logic signed [bsr_pkg::CoordW-1:0] pen_x, pen_y;
  logic [bsr_pkg::SizeW-1:0]  width_reg, height_reg;
  logic [bsr_pkg::ThickW-1:0] thick_reg;
  logic [bsr_pkg::DataW-1:0]  color_reg;

  pixel_result_t pending_px[$];
  int mismatches;
  int unexpected;

  bit sender_idles;
  int burst_left;
  int stall_mode;
  int stall_cnt;

  function automatic longint canvas_w();
    if (width_reg == 0) return 1;
    if (width_reg > CanvasMax) return CanvasMax;
    return width_reg;
  endfunction

  function automatic longint canvas_h();
    if (height_reg == 0) return 1;
    if (height_reg > CanvasMax) return CanvasMax;
    return height_reg;
  endfunction

  function automatic void paint_brush(longint cx, longint cy);
    longint t, r, y0, y1, x0, x1, dx, dy;
    t = thick_reg;
    r = 0;
    if (t == 0) return;
    while ((r + 1) * (r + 1) < t) r++;
    y0 = cy - r; if (y0 < 0) y0 = 0;
    y1 = cy + r; if (y1 > canvas_h() - 1) y1 = canvas_h() - 1;
    x0 = cx - r; if (x0 < 0) x0 = 0;
    x1 = cx + r; if (x1 > canvas_w() - 1) x1 = canvas_w() - 1;
    for (longint k = y0; k <= y1; k++)
      for (longint l = x0; l <= x1; l++) begin
        dy = k - cy;
        dx = l - cx;
        if (dy * dy + dx * dx < t) canvas_px[k * CanvasMax + l] = color_reg;
      end
  endfunction

  function automatic void paint_segment(longint px, longint py);
    longint lx, ly, bx, by, w, h, c;
    bit rising;
    lx = pen_x;
    ly = pen_y;
    bx = px < lx ? px : lx;
    by = py < ly ? py : ly;
    w = (px > lx ? px : lx) - bx;
    h = (py > ly ? py : ly) - by;
    rising = (py >= ly && px >= lx) || (py <= ly && px <= lx);
    if (w > h) begin
      for (longint i = 0; i <= w; i++) begin
        c = rising ? i * h / w : (w - i) * h / w;
        paint_brush(bx + i, by + c);
      end
    end else if (h != 0) begin
      for (longint i = 0; i <= h; i++) begin
        c = rising ? w * i / h : w - w * i / h;
        paint_brush(bx + c, by + i);
      end
    end
  endfunction

  function automatic pixel_result_t paint_item(logic [bsr_pkg::KindW-1:0] kind,
                                               logic signed [bsr_pkg::CoordW-1:0] x,
                                               logic signed [bsr_pkg::CoordW-1:0] y,
                                               logic [bsr_pkg::DataW-1:0] data);
    pixel_result_t res;
    longint sx, sy;
    res.read_data = '0;
    res.outside = 1'b0;
    sx = x;
    sy = y;
    case (kind)
      bsr_pkg::KindStart: begin
        paint_brush(sx, sy);
        pen_x = x;
        pen_y = y;
      end
      bsr_pkg::KindMove: begin
        paint_segment(sx, sy);
        pen_x = x;
        pen_y = y;
      end
      bsr_pkg::KindStop: paint_segment(sx, sy);
      bsr_pkg::KindRead, bsr_pkg::KindWrite: begin
        if (sx < 0 || sy < 0 || sx >= canvas_w() || sy >= canvas_h()) begin
          res.outside = 1'b1;
        end else if (kind == bsr_pkg::KindRead) begin
          res.read_data = canvas_px[sy * CanvasMax + sx];
        end else begin
          canvas_px[sy * CanvasMax + sx] = data;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(logic [bsr_pkg::KindW-1:0] kind,
                           logic signed [bsr_pkg::CoordW-1:0] x,
                           logic signed [bsr_pkg::CoordW-1:0] y,
                           logic [bsr_pkg::DataW-1:0] data);
    if (sender_idles && burst_left == 0) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    items_if.valid      <= 1'b1;
    items_if.kind       <= kind;
    items_if.pos_x      <= x;
    items_if.pos_y      <= y;
    items_if.write_data <= data;
    do @(posedge clk); while (!items_if.ready);
    pending_px.push_back(paint_item(kind, x, y, data));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    items_if.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(bsr_pkg::cfg_idx_t idx, logic [bsr_pkg::DataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      bsr_pkg::CFG_WIDTH:  width_reg = value[bsr_pkg::SizeW-1:0];
      bsr_pkg::CFG_HEIGHT: height_reg = value[bsr_pkg::SizeW-1:0];
      bsr_pkg::CFG_THICK:  thick_reg = value[bsr_pkg::ThickW-1:0];
      bsr_pkg::CFG_COLOR:  color_reg = value;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_mode)
      0: results_if.ready <= 1'b1;
      1: results_if.ready <= ($urandom_range(0, 9) < 7);
      default: results_if.ready <= (stall_cnt[4:2] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_px.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result: read_data=%h outside=%b",
                   results_if.read_data, results_if.outside);
      end else begin
        exp_px = pending_px.pop_front();
        if (exp_px.read_data !== results_if.read_data ||
            exp_px.outside !== results_if.outside) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: read_data exp %h got %h, outside exp %b got %b",
                     exp_px.read_data, results_if.read_data,
                     exp_px.outside, results_if.outside);
        end
      end
    end
  end

  function automatic logic signed [bsr_pkg::CoordW-1:0] near_x();
    return bsr_pkg::CoordW'(int'($urandom_range(0, canvas_w() + 12)) - 6);
  endfunction

  function automatic logic signed [bsr_pkg::CoordW-1:0] near_y();
    return bsr_pkg::CoordW'(int'($urandom_range(0, canvas_h() + 12)) - 6);
  endfunction

  task automatic test_pixel_access();
    send_item(bsr_pkg::KindRead, 16'sd0, 16'sd0, '0);
    send_item(bsr_pkg::KindWrite, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
    send_item(bsr_pkg::KindWrite, 16'sd255, 16'sd255, 32'hA5A5_5A5A);
    send_item(bsr_pkg::KindRead, 16'sd0, 16'sd0, '0);
    send_item(bsr_pkg::KindRead, 16'sd255, 16'sd255, '0);
    send_item(bsr_pkg::KindWrite, -16'sd32768, 16'sd32767, 32'h1234_5678);
    send_item(bsr_pkg::KindRead, 16'sd32767, -16'sd32768, '0);
    send_item(bsr_pkg::KindRead, 16'sd256, 16'sd0, '0);
    send_item(bsr_pkg::KindRead, 16'sd0, -16'sd1, '0);
    for (int k = KindSpare; k <= 7; k++)
      send_item(bsr_pkg::KindW'(k), 16'sd5, 16'sd5, '1);
  endtask

  task automatic test_stroke_shapes();
    write_reg(bsr_pkg::CFG_COLOR, 32'hFF00_00FF);
    write_reg(bsr_pkg::CFG_THICK, 8'd5);
    send_item(bsr_pkg::KindStart, 16'sd10, 16'sd10, '0);
    send_item(bsr_pkg::KindMove, 16'sd20, 16'sd13, '0);
    send_item(bsr_pkg::KindMove, 16'sd15, 16'sd30, '0);
    send_item(bsr_pkg::KindMove, 16'sd25, 16'sd22, '0);
    send_item(bsr_pkg::KindStop, 16'sd5, 16'sd28, '0);
    send_item(bsr_pkg::KindStop, 16'sd25, 16'sd22, '0);
    send_item(bsr_pkg::KindMove, 16'sd25, 16'sd22, '0);
    send_item(bsr_pkg::KindRead, 16'sd15, 16'sd30, '0);
    send_item(bsr_pkg::KindStart, 16'sd1, 16'sd0, '0);
    send_item(bsr_pkg::KindMove, -16'sd3, 16'sd2, '0);
    send_item(bsr_pkg::KindStart, -16'sd32768, -16'sd32768, '0);
    send_item(bsr_pkg::KindMove, -16'sd32762, -16'sd32765, '0);
    send_item(bsr_pkg::KindStart, 16'sd32767, 16'sd32767, '0);
    send_item(bsr_pkg::KindStop, 16'sd32761, 16'sd32767, '0);
    drain();
    write_reg(bsr_pkg::CFG_THICK, 8'd0);
    send_item(bsr_pkg::KindStart, 16'sd40, 16'sd40, '0);
    send_item(bsr_pkg::KindMove, 16'sd44, 16'sd41, '0);
    send_item(bsr_pkg::KindRead, 16'sd40, 16'sd40, '0);
    drain();
    write_reg(bsr_pkg::CFG_THICK, 8'd255);
    write_reg(bsr_pkg::CFG_COLOR, 32'h0000_0000);
    send_item(bsr_pkg::KindStart, 16'sd250, 16'sd3, '0);
    send_item(bsr_pkg::KindMove, 16'sd252, 16'sd4, '0);
    send_item(bsr_pkg::KindRead, 16'sd240, 16'sd3, '0);
    drain();
  endtask

  task automatic test_canvas_sizes();
    logic [bsr_pkg::DataW-1:0] sizes [4];
    sizes = '{32'd0, 32'h1FF, 32'd1, 32'hFFFF_FF05};
    write_reg(bsr_pkg::CFG_THICK, 8'd2);
    write_reg(bsr_pkg::CFG_COLOR, 32'h00C0_FFEE);
    foreach (sizes[i]) begin
      write_reg(bsr_pkg::CFG_WIDTH, sizes[i]);
      write_reg(bsr_pkg::CFG_HEIGHT, sizes[3 - i]);
      send_item(bsr_pkg::KindStart, 16'sd0, 16'sd0, '0);
      send_item(bsr_pkg::KindRead, 16'sd0, 16'sd0, '0);
      send_item(bsr_pkg::KindRead, 16'sd4, 16'sd1, '0);
      send_item(bsr_pkg::KindWrite, 16'sd255, 16'sd2, 32'h0BAD_F00D);
      drain();
    end
  endtask

  task automatic test_random_strokes();
    logic signed [bsr_pkg::CoordW-1:0] x, y;
    for (int phase = 0; phase < 12; phase++) begin
      sender_idles = (phase % 3 != 2);
      stall_mode = phase % 3;
      write_reg(bsr_pkg::CFG_WIDTH, phase == 0 ? 32'd256 : $urandom_range(1, 300));
      write_reg(bsr_pkg::CFG_HEIGHT, phase == 1 ? 32'd1 : $urandom_range(1, 300));
      write_reg(bsr_pkg::CFG_THICK, phase == 5 ? 32'd255 : $urandom_range(0, 12));
      write_reg(bsr_pkg::CFG_COLOR, $urandom);
      for (int n = 0; n < 45; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            x = near_x();
            y = near_y();
            send_item(bsr_pkg::KindStart, x, y, $urandom);
            repeat ($urandom_range(0, phase == 5 ? 1 : 4)) begin
              x = x + bsr_pkg::CoordW'(int'($urandom_range(0, 12)) - 6);
              y = y + bsr_pkg::CoordW'(int'($urandom_range(0, 12)) - 6);
              send_item(bsr_pkg::KindMove, x, y, $urandom);
              n++;
            end
            send_item($urandom_range(0, 1) ? bsr_pkg::KindStop : bsr_pkg::KindMove,
                      x + bsr_pkg::CoordW'(int'($urandom_range(0, 6)) - 3),
                      y + bsr_pkg::CoordW'(int'($urandom_range(0, 6)) - 3), $urandom);
            n += 2;
          end
          5, 6: send_item(bsr_pkg::KindRead, near_x(), near_y(), $urandom);
          7: send_item(bsr_pkg::KindWrite, near_x(), near_y(), $urandom);
          8: send_item($urandom_range(0, 1) ? bsr_pkg::KindRead : bsr_pkg::KindWrite,
                       bsr_pkg::CoordW'($urandom), bsr_pkg::CoordW'($urandom), $urandom);
          default: send_item(bsr_pkg::KindW'($urandom_range(0, 7)),
                             bsr_pkg::CoordW'($urandom),
                             bsr_pkg::CoordW'($urandom), $urandom);
        endcase
      end
      drain();
    end
  endtask

  initial begin
    items_if.valid = 1'b0;
    items_if.kind = bsr_pkg::KindStart;
    items_if.pos_x = '0;
    items_if.pos_y = '0;
    items_if.write_data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = bsr_pkg::CFG_WIDTH;
    cfg_if.data = '0;
    results_if.ready = 1'b0;
    stall_cnt = 0;
    stall_mode = 1;
    sender_idles = 1'b1;
    burst_left = 0;
    mismatches = 0;
    unexpected = 0;
    foreach (canvas_px[i]) canvas_px[i] = '0;
    pen_x = '0;
    pen_y = '0;
    width_reg = bsr_pkg::CanvasSizeReset;
    height_reg = bsr_pkg::CanvasSizeReset;
    thick_reg = bsr_pkg::ThickReset;
    color_reg = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pixel_access();
    drain();
    test_stroke_shapes();
    test_canvas_sizes();
    test_random_strokes();
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && pending_px.size() == 0) begin
      $display("brush_stroke_rasterizer_top regression: pass");
    end else begin
      $display("brush_stroke_rasterizer_top regression: fail");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("brush_stroke_rasterizer_top regression: fail");
    $finish;
  end

endmodule
